### rtl/ggh_pkg.sv
package ggh_pkg;

	localparam int CordicSteps = 16;
	localparam int StepW = 5;

	typedef enum logic [1:0] {
		OP_POSE  = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DRIVING  = 3'd1,
		ST_ARRIVED  = 3'd2,
		ST_CANCELED = 3'd3,
		ST_REJECTED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_TARGET_X = 3'd0,
		REG_TARGET_Y = 3'd1,
		REG_TOLERANCE = 3'd2,
		REG_MAX_SPEED = 3'd3,
		REG_LIN_GAIN = 3'd4,
		REG_ANG_GAIN = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_SQRT,
		FSM_DECIDE,
		FSM_VEC_INIT,
		FSM_VEC,
		FSM_ERR,
		FSM_ROT,
		FSM_MUL1,
		FSM_MUL2,
		FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic vec_init;
		logic vec_step;
		logic err_calc;
		logic rot_step;
		logic mul1;
		logic mul2;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic cordic_done;
		logic active_goal;
		logic stop_goal;
	} sts_t;

	localparam logic signed [15:0] PiQ13 = 16'sd25736;
	localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;
	localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
	localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;
	localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;
	localparam logic [15:0] SpawnPos = 16'd5678;

	function automatic logic signed [31:0] atan_q28(input logic [StepW-1:0] i);
		logic signed [31:0] r;
		begin
			unique case (i)
				5'd0: r = 32'sd210828714;
				5'd1: r = 32'sd124459457;
				5'd2: r = 32'sd65760959;
				5'd3: r = 32'sd33381290;
				5'd4: r = 32'sd16755422;
				5'd5: r = 32'sd8385879;
				5'd6: r = 32'sd4193963;
				5'd7: r = 32'sd2097109;
				5'd8: r = 32'sd1048571;
				5'd9: r = 32'sd524287;
				5'd10: r = 32'sd262144;
				5'd11: r = 32'sd131072;
				5'd12: r = 32'sd65536;
				5'd13: r = 32'sd32768;
				5'd14: r = 32'sd16384;
				5'd15: r = 32'sd8192;
				5'd16: r = 32'sd4096;
				5'd17: r = 32'sd2048;
				5'd18: r = 32'sd1024;
				5'd19: r = 32'sd512;
				5'd20: r = 32'sd256;
				5'd21: r = 32'sd128;
				5'd22: r = 32'sd64;
				5'd23: r = 32'sd32;
				default: r = 32'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

### rtl/ggh_ctrl.sv
module ggh_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] op,
	input  ggh_pkg::sts_t sts,
	input  logic out_free,
	output ggh_pkg::cmd_t cmd,
	output logic busy
);
	import ggh_pkg::*;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != FSM_IDLE);
		unique case (state_q)
			FSM_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (op == OP_TICK && sts.active_goal) state_d = FSM_SQRT;
					else state_d = FSM_OUT;
				end
			end
			FSM_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.sqrt_done) state_d = FSM_DECIDE;
			end
			FSM_DECIDE: begin
				if (sts.stop_goal) state_d = FSM_OUT;
				else state_d = FSM_VEC_INIT;
			end
			FSM_VEC_INIT: begin
				cmd.vec_init = 1'b1;
				state_d = FSM_VEC;
			end
			FSM_VEC: begin
				cmd.vec_step = 1'b1;
				if (sts.cordic_done) state_d = FSM_ERR;
			end
			FSM_ERR: begin
				cmd.err_calc = 1'b1;
				state_d = FSM_ROT;
			end
			FSM_ROT: begin
				cmd.rot_step = 1'b1;
				if (sts.cordic_done) state_d = FSM_MUL1;
			end
			FSM_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = FSM_MUL2;
			end
			FSM_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = FSM_OUT;
			end
			FSM_OUT: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end
endmodule

### rtl/ggh_datapath.sv
module ggh_datapath (
	input  logic clk,
	input  logic arst_n,
	input  ggh_pkg::cmd_t cmd,
	output ggh_pkg::sts_t sts,
	input  logic [1:0] operation,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	input  logic cancel_request,
	input  logic signed [15:0] target_x,
	input  logic signed [15:0] target_y,
	input  logic [15:0] tolerance,
	input  logic [15:0] speed_limit,
	input  logic [11:0] linear_gain,
	input  logic [11:0] angular_gain,
	output logic [15:0] res_speed,
	output logic signed [15:0] res_turn,
	output logic [15:0] res_dist,
	output logic [2:0] res_status,
	output logic [15:0] res_ticks
);
	import ggh_pkg::*;

	logic signed [15:0] held_x_q, held_y_q, held_heading_q;
	logic goal_active_q;
	logic [15:0] tick_count_q;
	logic cancel_q;
	logic signed [16:0] dx_q, dy_q;
	logic [35:0] rem_q;
	logic [17:0] root_q;
	logic [4:0] sq_cnt_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [35:0] cz_q;
	logic [StepW-1:0] it_q;
	logic signed [17:0] err_q;
	logic [16:0] cos_q;
	logic [33:0] prod1_q;
	logic [15:0] speed_q;
	logic signed [15:0] turn_q;
	logic [2:0] status_q;

	// Restoring square root, one result bit per cycle.
	logic signed [35:0] sh_x, sh_y;
	logic signed [31:0] at;
	logic vec_up, rot_up;
	logic signed [35:0] v_sq;
	always_comb begin
		sh_x = cx_q >>> it_q;
		sh_y = cy_q >>> it_q;
		at = atan_q28(it_q);
		vec_up = (cy_q > 0);
		rot_up = (cz_q >= 0);
		v_sq = 36'(dx_q * dx_q) + 36'(dy_q * dy_q);
	end

	// Yaw error from the bearing.
	logic signed [35:0] bz;
	logic signed [17:0] bearing, e0, e1;
	always_comb begin
		bz = (cz_q + 36'sd16384) >>> 15;
		bearing = (dx_q == 0 && dy_q == 0) ? 18'sd0 : bz[17:0];
		e0 = bearing - 18'(held_heading_q);
		if (e0 > 18'(PiQ13)) e1 = e0 - 18'(TwoPiQ13);
		else if (e0 < -18'(PiQ13)) e1 = e0 + 18'(TwoPiQ13);
		else e1 = e0;
	end

	logic signed [35:0] cx_round;
	logic [28:0] p2;
	logic signed [31:0] tprod;
	logic signed [23:0] tq;
	always_comb begin
		cx_round = (cx_q + 36'sd8192) >>> 14;
		p2 = 29'({17'd0, linear_gain} * {11'd0, root_q});
		tprod = 32'($signed({1'b0, angular_gain})) * 32'(err_q);
		tq = 24'((tprod + 32'sd128) >>> 8);
	end

	logic [15:0] dist_sat;
	always_comb dist_sat = (root_q > 18'd65535) ? 16'hFFFF : root_q[15:0];

	assign sts.sqrt_done = (sq_cnt_q == 5'd19);
	assign sts.cordic_done = (it_q == StepW'(CordicSteps - 1));
	assign sts.active_goal = goal_active_q;
	assign sts.stop_goal = cancel_q || ({2'b0, root_q} <= {4'd0, tolerance});

	logic [49:0] sp_prod;
	always_comb sp_prod = {16'd0, prod1_q} * {33'd0, cos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q <= SpawnPos;
			held_y_q <= SpawnPos;
			held_heading_q <= '0;
			goal_active_q <= 1'b0;
			tick_count_q <= '0;
		end else begin
			if (cmd.load) begin
				unique case (op_t'(operation))
					OP_POSE: begin
						held_x_q <= pose_x;
						held_y_q <= pose_y;
						held_heading_q <= pose_heading;
					end
					OP_START: begin
						if (speed_limit != 0 && tolerance != 0 && !goal_active_q) begin
							goal_active_q <= 1'b1;
							tick_count_q <= '0;
						end
					end
					OP_TICK: begin
						if (goal_active_q && tick_count_q != 16'hFFFF)
							tick_count_q <= tick_count_q + 16'd1;
					end
					default: ;
				endcase
			end
			if (cmd.sqrt_step && sts.sqrt_done && sts.stop_goal)
				goal_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cancel_q <= cancel_request;
			dx_q <= 17'(target_x) - 17'(held_x_q);
			dy_q <= 17'(target_y) - 17'(held_y_q);
			sq_cnt_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			speed_q <= '0;
			turn_q <= '0;
			res_dist <= '0;
			if (operation == OP_START)
				status_q <= (speed_limit == 0 || tolerance == 0 || goal_active_q)
					? ST_REJECTED : ST_DRIVING;
			else
				status_q <= goal_active_q ? ST_DRIVING : ST_IDLE;
		end
		if (cmd.sqrt_step) begin
			if (sq_cnt_q == 5'd0) begin
				cx_q <= v_sq;
				sq_cnt_q <= 5'd1;
			end else if (!sts.sqrt_done) begin
				if ({rem_q[33:0], cx_q[35:34]} >= {16'd0, root_q, 2'b01}) begin
					rem_q <= {rem_q[33:0], cx_q[35:34]} - {16'd0, root_q, 2'b01};
					root_q <= {root_q[16:0], 1'b1};
				end else begin
					rem_q <= {rem_q[33:0], cx_q[35:34]};
					root_q <= {root_q[16:0], 1'b0};
				end
				cx_q <= cx_q <<< 2;
				sq_cnt_q <= sq_cnt_q + 5'd1;
			end else begin
				res_dist <= dist_sat;
				if (cancel_q) status_q <= ST_CANCELED;
				else if (sts.stop_goal) status_q <= ST_ARRIVED;
			end
		end
		if (cmd.vec_init) begin
			it_q <= '0;
			if (dx_q < 0) begin
				if (dy_q >= 0) begin
					cx_q <= 36'(dy_q) <<< 8;
					cy_q <= -(36'(dx_q) <<< 8);
					cz_q <= 36'(HalfPiQ28);
				end else begin
					cx_q <= -(36'(dy_q) <<< 8);
					cy_q <= 36'(dx_q) <<< 8;
					cz_q <= -36'(HalfPiQ28);
				end
			end else begin
				cx_q <= 36'(dx_q) <<< 8;
				cy_q <= 36'(dy_q) <<< 8;
				cz_q <= '0;
			end
		end
		if (cmd.vec_step) begin
			if (vec_up) begin
				cx_q <= cx_q + sh_y; cy_q <= cy_q - sh_x; cz_q <= cz_q + 36'(at);
			end else begin
				cx_q <= cx_q - sh_y; cy_q <= cy_q + sh_x; cz_q <= cz_q - 36'(at);
			end
			it_q <= it_q + 1'b1;
		end
		if (cmd.err_calc) begin
			err_q <= e1;
			it_q <= '0;
			cx_q <= 36'(CordicGainQ30);
			cy_q <= '0;
			cz_q <= 36'(e1) <<< 15;
		end
		if (cmd.rot_step) begin
			if (rot_up) begin
				cx_q <= cx_q - sh_y; cy_q <= cy_q + sh_x; cz_q <= cz_q - 36'(at);
			end else begin
				cx_q <= cx_q + sh_y; cy_q <= cy_q - sh_x; cz_q <= cz_q + 36'(at);
			end
			it_q <= it_q + 1'b1;
		end
		if (cmd.mul1) begin
			if (err_q > -18'(HalfPiQ13) && err_q < 18'(HalfPiQ13) && cx_q >= 0)
				cos_q <= cx_round[16:0];
			else
				cos_q <= '0;
			prod1_q <= {5'd0, p2};
			if (tq > 24'sd16384) turn_q <= 16'sd16384;
			else if (tq < -24'sd16384) turn_q <= -16'sd16384;
			else turn_q <= tq[15:0];
		end
		if (cmd.mul2) begin
			if (((sp_prod + 50'd8388608) >> 24) > {34'd0, speed_limit})
				speed_q <= speed_limit;
			else
				speed_q <= 16'(((sp_prod + 50'd8388608) >> 24));
		end
	end

	assign res_speed = speed_q;
	assign res_turn = turn_q;
	assign res_status = status_q;
	assign res_ticks = tick_count_q;
endmodule

### rtl/go_to_goal_heading_controller.sv
// Go-to-goal heading controller for a unicycle robot.
// Input channel: operation, pose_x, pose_y, pose_heading, cancel_request with
// in_valid/in_stall. One item is taken only while the block is idle.
// Output channel: speed_cmd, turn_cmd, distance_left, status, ticks_used with
// out_valid/out_stall. Every input item yields exactly one result item.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always ready.
// Pose updates, starts and idle ticks go from the load straight to the output
// state. A tick on an active goal runs an 18-step square root; unless the goal
// is reached or cancelled, it then runs a 16-step vectoring CORDIC and a
// 16-step rotation CORDIC on one shared shift add unit, plus two multiply steps.
// The result register holds its item while out_stall is high; a new input item
// can be processing while the previous result waits, but the block finishes
// only when the register is free.
// Reset puts the robot pose at the spawn point (5678, 5678), heading zero,
// no goal active, gains at 1.0 and 3.0.
module go_to_goal_heading_controller (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] operation,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	input  logic cancel_request,
	output logic out_valid,
	input  logic out_stall,
	output logic [15:0] speed_cmd,
	output logic signed [15:0] turn_cmd,
	output logic [15:0] distance_left,
	output logic [2:0] status,
	output logic [15:0] ticks_used,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import ggh_pkg::*;

	logic signed [15:0] target_x_q, target_y_q;
	logic [15:0] tolerance_q, speed_limit_q;
	logic [11:0] linear_gain_q, angular_gain_q;
	cmd_t cmd;
	sts_t sts;
	logic busy, start, out_free;
	logic [15:0] r_speed, r_dist, r_ticks;
	logic signed [15:0] r_turn;
	logic [2:0] r_status;

	assign cfg_ready = 1'b1;
	assign in_stall = busy;
	assign start = in_valid && !busy;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0; target_y_q <= '0;
			tolerance_q <= '0; speed_limit_q <= '0;
			linear_gain_q <= 12'd256; angular_gain_q <= 12'd768;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TARGET_X: target_x_q <= cfg_data;
				REG_TARGET_Y: target_y_q <= cfg_data;
				REG_TOLERANCE: tolerance_q <= cfg_data;
				REG_MAX_SPEED: speed_limit_q <= cfg_data;
				REG_LIN_GAIN: linear_gain_q <= cfg_data[11:0];
				REG_ANG_GAIN: angular_gain_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	ggh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(operation), .sts(sts),
		.out_free(out_free), .cmd(cmd), .busy(busy)
	);

	ggh_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.operation(operation), .pose_x(pose_x), .pose_y(pose_y),
		.pose_heading(pose_heading), .cancel_request(cancel_request),
		.target_x(target_x_q), .target_y(target_y_q), .tolerance(tolerance_q),
		.speed_limit(speed_limit_q), .linear_gain(linear_gain_q),
		.angular_gain(angular_gain_q), .res_speed(r_speed), .res_turn(r_turn),
		.res_dist(r_dist), .res_status(r_status), .res_ticks(r_ticks)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.finish) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			speed_cmd <= r_speed;
			turn_cmd <= r_turn;
			distance_left <= r_dist;
			status <= r_status;
			ticks_used <= r_ticks;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("accepted while busy");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> out_free) else $error("result overwritten");
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (turn_cmd <= 16'sd16384 && turn_cmd >= -16'sd16384))
		else $error("turn out of range");
`endif
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ggh_pkg::*;

	typedef struct {
		logic [15:0] speed;
		logic signed [15:0] turn;
		logic [15:0] dleft;
		logic [2:0] stat;
		logic [15:0] ticks;
	} drive_cmd_t;

	class goal_scoreboard;
		drive_cmd_t cmd_q[$];
		int errors = 0;
		logic [15:0] tgt_x, tgt_y, tol, max_spd, pos_x, pos_y, heading, tick_cnt;
		logic [11:0] lin_gain, ang_gain;
		bit active;

		function new();
			tgt_x = 0; tgt_y = 0; tol = 0; max_spd = 0;
			lin_gain = 256; ang_gain = 768;
			pos_x = 16'd5678; pos_y = 16'd5678; heading = 0;
			active = 0; tick_cnt = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] val);
			case (idx)
				REG_TARGET_X: tgt_x = val;
				REG_TARGET_Y: tgt_y = val;
				REG_TOLERANCE: tol = val;
				REG_MAX_SPEED: max_spd = val;
				REG_LIN_GAIN: lin_gain = val[11:0];
				REG_ANG_GAIN: ang_gain = val[11:0];
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		// atan2(y, x) in Q13 via vectoring shift-add iterations on Q28 angle.
		function longint bearing(longint x, longint y);
			longint z, t, nx, ny;
			z = 0;
			if (x == 0 && y == 0) return 0;
			x = x * 256;
			y = y * 256;
			if (x < 0) begin
				if (y >= 0) begin
					t = x; x = y; y = -t; z = HalfPiQ28;
				end else begin
					t = x; x = -y; y = t; z = -HalfPiQ28;
				end
			end
			for (int i = 0; i < CordicSteps && i < 24; i++) begin
				if (y > 0) begin
					nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_q28(StepW'(i));
				end else begin
					nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_q28(StepW'(i));
				end
				x = nx; y = ny;
			end
			return (z + 16384) >>> 15;
		endfunction

		function longint cosine(longint e);
			longint x, y, z, nx, ny;
			x = CordicGainQ30; y = 0; z = e * 32768;
			for (int i = 0; i < CordicSteps && i < 24; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_q28(StepW'(i));
				end else begin
					nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_q28(StepW'(i));
				end
				x = nx; y = ny;
			end
			if (x < 0) x = 0;
			return (x + 8192) >>> 14;
		endfunction

		function void note_input(op_t op, logic [15:0] px, logic [15:0] py,
				logic [15:0] ph, bit cancel);
			drive_cmd_t r;
			longint dx, dy, err, c, turn, sx, sy;
			longint unsigned dist_val, spd;
			r.speed = 0; r.turn = 0; r.dleft = 0;
			r.stat = active ? ST_DRIVING : ST_IDLE;
			if (op == OP_POSE) begin
				pos_x = px; pos_y = py; heading = ph;
			end else if (op == OP_START) begin
				if (max_spd == 0 || tol == 0 || active)
					r.stat = ST_REJECTED;
				else begin
					active = 1; tick_cnt = 0; r.stat = ST_DRIVING;
				end
			end else if (op == OP_TICK && active) begin
				sx = $signed(tgt_x); sy = $signed(pos_x); dx = sx - sy;
				sx = $signed(tgt_y); sy = $signed(pos_y); dy = sx - sy;
				dist_val = int_sqrt(dx * dx + dy * dy);
				if (tick_cnt != 16'hFFFF) tick_cnt++;
				r.dleft = dist_val > 65535 ? 16'hFFFF : dist_val[15:0];
				if (cancel) begin
					active = 0; r.stat = ST_CANCELED;
				end else if (dist_val <= tol) begin
					active = 0; r.stat = ST_ARRIVED;
				end else begin
					sx = $signed(heading);
					err = bearing(dx, dy) - sx;
					if (err > PiQ13) err = err - TwoPiQ13;
					else if (err < -PiQ13) err = err + TwoPiQ13;
					c = 0;
					if (err > -HalfPiQ13 && err < HalfPiQ13) c = cosine(err);
					spd = (longint'(lin_gain) * dist_val * c + (64'd1 << 23)) >> 24;
					if (spd > max_spd) spd = max_spd;
					turn = (longint'(ang_gain) * err + 128) >>> 8;
					if (turn > 16384) turn = 16384;
					if (turn < -16384) turn = -16384;
					r.speed = spd[15:0];
					r.turn = turn[15:0];
					r.stat = ST_DRIVING;
				end
			end
			r.ticks = tick_cnt;
			cmd_q.push_back(r);
		endfunction

		task report(string field, longint got, longint want);
			$display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
			errors++;
		endtask

		task check_result(drive_cmd_t got);
			drive_cmd_t want;
			if (cmd_q.size() == 0) begin
				report("unexpected result status", got.stat, -1);
				return;
			end
			want = cmd_q.pop_front();
			if (got.speed !== want.speed) report("speed_cmd", got.speed, want.speed);
			if (got.turn !== want.turn) report("turn_cmd", got.turn, want.turn);
			if (got.dleft !== want.dleft) report("distance_left", got.dleft, want.dleft);
			if (got.stat !== want.stat) report("status", got.stat, want.stat);
			if (got.ticks !== want.ticks) report("ticks_used", got.ticks, want.ticks);
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, cancel_request, out_valid, out_stall;
	logic [1:0] operation;
	logic signed [15:0] pose_x, pose_y, pose_heading, turn_cmd;
	logic [15:0] speed_cmd, distance_left, ticks_used, cfg_data;
	logic [2:0] status, cfg_index;
	logic cfg_valid, cfg_ready;

	goal_scoreboard sb = new();
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_request = 0;

	go_to_goal_heading_controller u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .pose_x(pose_x), .pose_y(pose_y),
		.pose_heading(pose_heading), .cancel_request(cancel_request),
		.out_valid(out_valid), .out_stall(out_stall),
		.speed_cmd(speed_cmd), .turn_cmd(turn_cmd), .distance_left(distance_left),
		.status(status), .ticks_used(ticks_used),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 4000000);
		$display("Regression FAIL");
		$finish;
	end

	// Result side: random stalls plus one long hold-off on request.
	initial begin
		drive_cmd_t got;
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.speed = speed_cmd; got.turn = turn_cmd; got.dleft = distance_left;
				got.stat = status; got.ticks = ticks_used;
				sb.check_result(got);
			end
			if (hold_request) begin
				hold_request = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task send_item(op_t op, logic [15:0] px, logic [15:0] py, logic [15:0] ph, bit cancel);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pose_x <= px;
		pose_y <= py;
		pose_heading <= ph;
		cancel_request <= cancel;
		do @(posedge clk); while (in_stall);
		sb.note_input(op, px, py, ph, cancel);
	endtask

	task write_reg(reg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every result is back and the block has gone quiet.
	task drain();
		in_valid <= 1'b0;
		while (sb.cmd_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task set_goal(logic [15:0] tx, logic [15:0] ty, logic [15:0] tol, logic [15:0] mx,
			logic [15:0] lg, logic [15:0] ag);
		write_reg(REG_TARGET_X, tx);
		write_reg(REG_TARGET_Y, ty);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_MAX_SPEED, mx);
		write_reg(REG_LIN_GAIN, lg);
		write_reg(REG_ANG_GAIN, ag);
	endtask

	function logic [15:0] any_heading();
		return 16'($urandom_range(51472) - 25736);
	endfunction

	// Random mix of starts, poses, ticks and a few no-ops; poses land near the target
	// often enough that arrivals happen.
	task random_item();
		int pick;
		logic [15:0] px, py;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 35) begin
			px = sb.tgt_x + 16'($urandom_range(1024) - 512);
			py = sb.tgt_y + 16'($urandom_range(1024) - 512);
		end else begin
			px = 16'($urandom);
			py = 16'($urandom);
		end
		if (pick < 12)
			send_item(OP_START, 16'($urandom), 16'($urandom), any_heading(),
				1'($urandom_range(1)));
		else if (pick < 45)
			send_item(OP_POSE, px, py, any_heading(), 1'($urandom_range(1)));
		else if (pick < 96)
			send_item(OP_TICK, 16'($urandom), 16'($urandom), any_heading(),
				$urandom_range(99) < 8);
		else
			send_item(OP_NONE, px, py, any_heading(), 1'($urandom_range(1)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_POSE;
		pose_x = 0; pose_y = 0; pose_heading = 0;
		cancel_request = 1'b0;
		cfg_valid = 1'b0; cfg_index = REG_TARGET_X; cfg_data = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: a tick with no goal, then a start refused for zero limits.
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_START, 0, 0, 0, 1'b0);
		drain();
		write_reg(REG_TOLERANCE, 16'd100);
		drain();
		send_item(OP_START, 0, 0, 0, 1'b0);
		drain();
		write_reg(REG_MAX_SPEED, 16'd2000);
		drain();
		// Drive from the spawn point toward the origin, then refuse a second start.
		send_item(OP_START, 0, 0, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_START, 0, 0, 0, 1'b0);
		send_item(OP_POSE, 16'd5678, 16'd5678, 16'sd25736, 1'b1);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_POSE, 16'd5678, 16'd5678, -16'sd25736, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_NONE, 16'h7FFF, 16'h7FFF, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b1);
		// Arrival within tolerance and a pose exactly on the target.
		send_item(OP_START, 0, 0, 0, 1'b0);
		send_item(OP_POSE, 16'd50, -16'sd50, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_START, 0, 0, 0, 1'b0);
		send_item(OP_POSE, 0, 0, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		drain();
		// Far corner: distance saturates, full gains.
		set_goal(16'h8000, 16'h8000, 16'd1, 16'hFFFF, 16'd4095, 16'd4095);
		drain();
		send_item(OP_POSE, 16'h7FFF, 16'h7FFF, 16'sd12868, 1'b0);
		send_item(OP_START, 0, 0, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_POSE, 16'h7FFF, 16'h7FFF, -16'sd12868, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b0);
		send_item(OP_TICK, 0, 0, 0, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_goal(16'($urandom), 16'($urandom), 16'd300, 16'd3000, 16'd256, 16'd768);
				1: set_goal(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'd1, 16'd0, 16'd0);
				2: set_goal(16'h8000, 16'h7FFF, 16'd1, 16'hFFFF, 16'd4095, 16'd4095);
				default: set_goal(16'($urandom), 16'($urandom), 16'($urandom_range(1, 2000)),
					16'($urandom_range(1, 65535)), 16'($urandom_range(4095)),
					16'($urandom_range(4095)));
			endcase
			drain();
			if (ph < 2) begin
				send_idle_pct = 17; recv_idle_pct = 65;
			end else if (ph < 4) begin
				send_idle_pct = 65; recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			for (int n = 0; n < 330; n++) begin
				if (ph == 4 && n == 100) hold_request = 1;
				random_item();
			end
			drain();
		end

		if (sb.errors == 0 && sb.cmd_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
